### design/bpt_pkg.sv
package bpt_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int TRK_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COAST_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MARGIN  = 2'd2;

    // Configuration reset values.
    localparam logic [6:0]  TABLE_ENTRIES_RST = 7'd2;
    localparam logic [9:0]  COAST_GAIN_RST    = 10'd128;
    localparam logic [19:0] RANGE_MARGIN_RST  = 20'd5000;

    // Input word function codes.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Fix kind codes.
    localparam logic [1:0] FIX_NEIGHBOR = 2'd0;
    localparam logic [1:0] FIX_CURRENT  = 2'd1;
    localparam logic [1:0] FIX_COASTED  = 2'd2;
    localparam logic [1:0] FIX_FAILED   = 2'd3;

    // Fixed margins of the validity window, 0.01 mm.
    localparam logic signed [33:0] VALID_LO    = 34'sd20000;
    localparam logic signed [33:0] VALID_HI_UP = 34'sd820000;
    localparam logic signed [33:0] VALID_HI_DN = 34'sd920000;
    localparam logic signed [33:0] POS_MAX     = 34'sh0FFFFFFFF;

    typedef struct packed {
        logic               func;
        logic [5:0]         entry_index;
        logic [31:0]        seg_code_start;
        logic [31:0]        seg_code_end;
        logic [31:0]        seg_true_start;
        logic [31:0]        seg_true_end;
        logic [31:0]        raw_position;
        logic signed [15:0] raw_velocity;
    } in_word_t;

    typedef struct packed {
        logic [31:0] abs_position;
        logic [5:0]  track_index;
        logic [1:0]  fix_kind;
        logic        position_valid;
    } out_word_t;

    // One table entry as held in the segment memory.
    typedef struct packed {
        logic [31:0] code_start;
        logic [31:0] code_end;
        logic [31:0] true_start;
        logic [31:0] true_end;
    } seg_entry_t;

    // Results of testing one entry against the reading.
    typedef struct packed {
        logic        in_range;
        logic        in_valid;
        logic [31:0] mapped_pos;
    } eval_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_FETCH_CUR,
        ST_CHOOSE,
        ST_TEST_OTHER,
        ST_TEST_CUR,
        ST_COAST,
        ST_FIN
    } state_t;

    // Clamp a signed intermediate position to the 32-bit output range.
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > POS_MAX) begin
            r = '1;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/bpt_ram.sv
module bpt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Simple dual-port memory with a registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/bpt_eval.sv
module bpt_eval (
    input  bpt_pkg::seg_entry_t entry,
    input  logic [31:0]         reading,
    input  logic [19:0]         margin,
    output bpt_pkg::eval_res_t  res
);
    import bpt_pkg::*;

    logic signed [33:0] b;
    logic signed [33:0] cs;
    logic signed [33:0] ce;
    logic signed [33:0] ts;
    logic signed [33:0] m;
    logic               up_range;
    logic               up_map;
    logic               range_up;
    logic               range_dn;
    logic               valid_up;
    logic               valid_dn;
    logic signed [33:0] map_sum;

    assign b  = $signed({2'b00, reading});
    assign cs = $signed({2'b00, entry.code_start});
    assign ce = $signed({2'b00, entry.code_end});
    assign ts = $signed({2'b00, entry.true_start});
    assign m  = $signed({14'd0, margin});

    // Direction of the segment: strict for the window tests, inclusive for mapping.
    assign up_range = entry.code_start < entry.code_end;
    assign up_map   = entry.code_start <= entry.code_end;

    // Guarded window test with the configured margin.
    assign range_up = (b >= cs + m) && (b <= ce - m);
    assign range_dn = (b <= cs - m) && (b >= ce + m);

    // Validity window with the fixed margins.
    assign valid_up = (b >= cs + VALID_LO) && (b <= ce - VALID_HI_UP);
    assign valid_dn = (b <= cs - VALID_HI_DN) && (b >= ce + VALID_LO);

    // Barcode reading mapped to the actual track position.
    assign map_sum = up_map ? (ts + (b - cs)) : (ts + (cs - b));

    always_comb begin
        res.in_range   = up_range ? range_up : range_dn;
        res.in_valid   = up_range ? valid_up : valid_dn;
        res.mapped_pos = sat32(map_sum);
    end

endmodule

### design/segmented_barcode_position_tracker_core.sv
// Segmented barcode position tracker.
// Input words arrive on s_valid/s_ready/s_word. A load word (func 0) writes
// one segment into the table memory in the cycle it is accepted and gives no
// result. A sample word (func 1) gives exactly one result word on
// m_valid/m_ready/m_word. Configuration registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, the block itself does not enforce this. One sample is processed at a
// time; s_ready is high only while idle. A locked sample goes through three
// table reads, the neighbor choice, up to two window tests and a coast step
// before m_valid. An unlocked sample first walks the table memory one entry
// per cycle through its single read port, up to the number of segments in use.
// The result waits in an output register; the next word is accepted while it
// waits, but a following sample holds its result until m_ready drains the
// register. Reset (aresetn low, synchronous) unlocks the tracker, clears the
// current segment and last good position and restores the register defaults.
// The table memory is not cleared and must be loaded before use.
module segmented_barcode_position_tracker_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  bpt_pkg::in_word_t                    s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output bpt_pkg::out_word_t                   m_word,
    input  logic                                 cfg_we,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import bpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [6:0]  table_entries_reg;
    logic [9:0]  coast_gain_reg;
    logic [19:0] range_margin_reg;

    // Tracker state.
    logic             locked_reg;
    logic [IDX_W-1:0] cur_seg_reg;
    logic [31:0]      last_good_reg;

    // Per-sample working registers.
    logic [31:0]        b_reg;
    logic signed [15:0] vel_reg;
    logic [31:0]        prev_reg;
    logic [IDX_W-1:0]   c_reg;
    logic [IDX_W-1:0]   srch_addr_reg;
    logic               issue_more_reg;
    logic [IDX_W-1:0]   chk_idx_reg;
    logic               chk_vld_reg;
    seg_entry_t         lo_ent_reg;
    seg_entry_t         hi_ent_reg;
    seg_entry_t         cur_ent_reg;
    logic               other_is_lo_reg;
    logic signed [26:0] prod_reg;
    out_word_t          res_reg;

    // Output register.
    logic      m_valid_reg;
    out_word_t m_word_reg;

    // Combinational signals.
    logic               in_acc;
    logic               out_free;
    logic [IDX_W-1:0]   n_last;
    logic [IDX_W-1:0]   cur_clamped;
    logic [IDX_W-1:0]   lo_idx;
    logic [IDX_W-1:0]   hi_idx;
    logic [IDX_W-1:0]   other_idx;
    logic [IDX_W-1:0]   ram_rd_addr;
    seg_entry_t         ram_rd_data;
    logic               ram_wr_en;
    seg_entry_t         ram_wr_data;
    seg_entry_t         eval_ent;
    eval_res_t          ev;
    logic signed [33:0] dl;
    logic signed [33:0] dh;
    logic signed [33:0] dl_abs;
    logic signed [33:0] dh_abs;
    logic               other_is_lo;
    logic signed [33:0] coast_sum;
    logic [31:0]        coast_pos;
    logic               s_ready_c;

    assign in_acc   = s_valid && s_ready_c;
    assign out_free = !m_valid_reg || m_ready;

    // Last segment index in use, with table_entries clamped to the table.
    always_comb begin
        if (table_entries_reg < 7'd2) begin
            n_last = IDX_W'(1);
        end else if (32'(table_entries_reg) > 32'(TABLE_DEPTH)) begin
            n_last = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            n_last = IDX_W'(table_entries_reg - 7'd1);
        end
    end

    assign cur_clamped = (cur_seg_reg > n_last) ? n_last : cur_seg_reg;

    // Neighbors of the segment being tracked.
    assign lo_idx    = (c_reg == '0) ? c_reg : c_reg - IDX_W'(1);
    assign hi_idx    = (c_reg >= n_last) ? c_reg : c_reg + IDX_W'(1);
    assign other_idx = other_is_lo_reg ? lo_idx : hi_idx;

    // Distance of the reference position to each neighbor's near end.
    assign dl     = $signed({2'b00, prev_reg}) - $signed({2'b00, lo_ent_reg.true_end});
    assign dh     = $signed({2'b00, prev_reg}) - $signed({2'b00, hi_ent_reg.true_start});
    assign dl_abs = (dl < 0) ? -dl : dl;
    assign dh_abs = (dh < 0) ? -dh : dh;
    assign other_is_lo = (lo_idx != c_reg) && ((hi_idx == c_reg) || (dl_abs <= dh_abs));

    // Coasted position: previous position plus floor(velocity * gain / 256).
    assign coast_sum = $signed({2'b00, prev_reg}) + 34'(prod_reg >>> 8);
    assign coast_pos = sat32(coast_sum);

    // Table memory write from load words.
    assign ram_wr_en = in_acc && (s_word.func == FUNC_LOAD)
                       && (32'(s_word.entry_index) < 32'(TABLE_DEPTH));
    assign ram_wr_data = '{code_start: s_word.seg_code_start,
                           code_end:   s_word.seg_code_end,
                           true_start: s_word.seg_true_start,
                           true_end:   s_word.seg_true_end};

    bpt_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH($bits(seg_entry_t))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(s_word.entry_index)),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bpt_eval u_eval (
        .entry   (eval_ent),
        .reading (b_reg),
        .margin  (range_margin_reg),
        .res     (ev)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_word.func == FUNC_SAMPLE) begin
                    state_next = locked_reg ? ST_FETCH_LO : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (chk_vld_reg && ev.in_range) begin
                    state_next = ST_FETCH_LO;
                end else if (chk_vld_reg && chk_idx_reg == n_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FETCH_LO:  state_next = ST_FETCH_HI;
            ST_FETCH_HI:  state_next = ST_FETCH_CUR;
            ST_FETCH_CUR: state_next = ST_CHOOSE;
            ST_CHOOSE:    state_next = ST_TEST_OTHER;
            ST_TEST_OTHER: begin
                state_next = ev.in_range ? ST_FIN : ST_TEST_CUR;
            end
            ST_TEST_CUR: begin
                state_next = ev.in_range ? ST_FIN : ST_COAST;
            end
            ST_COAST: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs: read address, entry under test and input ready.
    always_comb begin
        ram_rd_addr = c_reg;
        eval_ent    = cur_ent_reg;
        s_ready_c   = 1'b0;
        unique case (state_reg)
            ST_IDLE:       s_ready_c = 1'b1;
            ST_SEARCH: begin
                ram_rd_addr = srch_addr_reg;
                eval_ent    = ram_rd_data;
            end
            ST_FETCH_LO:   ram_rd_addr = lo_idx;
            ST_FETCH_HI:   ram_rd_addr = hi_idx;
            ST_FETCH_CUR:  ram_rd_addr = c_reg;
            ST_TEST_OTHER: eval_ent = other_is_lo_reg ? lo_ent_reg : hi_ent_reg;
            ST_CHOOSE, ST_TEST_CUR, ST_COAST, ST_FIN: begin
                eval_ent = cur_ent_reg;
            end
            default: begin
                ram_rd_addr = c_reg;
            end
        endcase
    end

    // State register, configuration and tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            table_entries_reg <= TABLE_ENTRIES_RST;
            coast_gain_reg    <= COAST_GAIN_RST;
            range_margin_reg  <= RANGE_MARGIN_RST;
            locked_reg        <= 1'b0;
            cur_seg_reg       <= '0;
            last_good_reg     <= '0;
            issue_more_reg    <= 1'b0;
            chk_vld_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TABLE_ENTRIES: table_entries_reg <= cfg_data[6:0];
                    CFG_COAST_GAIN:    coast_gain_reg    <= cfg_data[9:0];
                    CFG_RANGE_MARGIN:  range_margin_reg  <= cfg_data[19:0];
                    default: ;
                endcase
            end

            // Search pipeline: one address issued and one entry checked per cycle.
            if (state_reg == ST_IDLE) begin
                issue_more_reg <= 1'b1;
                chk_vld_reg    <= 1'b0;
            end else if (state_reg == ST_SEARCH) begin
                chk_vld_reg <= issue_more_reg && (state_next == ST_SEARCH);
                if (srch_addr_reg == n_last) begin
                    issue_more_reg <= 1'b0;
                end
            end

            // Tracker state is updated when the fix is decided.
            if (state_reg == ST_TEST_OTHER && ev.in_range) begin
                locked_reg    <= 1'b1;
                cur_seg_reg   <= other_idx;
                last_good_reg <= ev.mapped_pos;
            end else if (state_reg == ST_TEST_CUR && ev.in_range) begin
                locked_reg    <= 1'b1;
                cur_seg_reg   <= c_reg;
                last_good_reg <= ev.mapped_pos;
            end else if (state_reg == ST_COAST) begin
                locked_reg  <= 1'b1;
                cur_seg_reg <= c_reg;
                if (!locked_reg) begin
                    last_good_reg <= coast_pos;
                end
            end
        end
    end

    // Working registers of the sample in flight.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                b_reg         <= s_word.raw_position;
                vel_reg       <= s_word.raw_velocity;
                c_reg         <= cur_clamped;
                prev_reg      <= locked_reg ? last_good_reg : s_word.raw_position;
                srch_addr_reg <= '0;
            end
            ST_SEARCH: begin
                chk_idx_reg <= srch_addr_reg;
                if (issue_more_reg) begin
                    srch_addr_reg <= srch_addr_reg + IDX_W'(1);
                end
                if (chk_vld_reg && ev.in_range) begin
                    c_reg <= chk_idx_reg;
                end else if (chk_vld_reg && chk_idx_reg == n_last) begin
                    res_reg <= '{abs_position: '0, track_index: '0,
                                 fix_kind: FIX_FAILED, position_valid: 1'b0};
                end
            end
            ST_FETCH_HI:  lo_ent_reg <= ram_rd_data;
            ST_FETCH_CUR: hi_ent_reg <= ram_rd_data;
            ST_CHOOSE: begin
                cur_ent_reg     <= ram_rd_data;
                other_is_lo_reg <= other_is_lo;
                prod_reg        <= 27'(vel_reg) * 27'($signed({1'b0, coast_gain_reg}));
            end
            ST_TEST_OTHER: begin
                res_reg.abs_position   <= ev.mapped_pos;
                res_reg.track_index    <= TRK_W'(other_idx);
                res_reg.fix_kind       <= FIX_NEIGHBOR;
                res_reg.position_valid <= locked_reg ? 1'b1 : ev.in_valid;
            end
            ST_TEST_CUR: begin
                res_reg.abs_position   <= ev.mapped_pos;
                res_reg.track_index    <= TRK_W'(c_reg);
                res_reg.fix_kind       <= FIX_CURRENT;
                res_reg.position_valid <= locked_reg ? 1'b1 : ev.in_valid;
            end
            ST_COAST: begin
                res_reg.abs_position   <= coast_pos;
                res_reg.track_index    <= TRK_W'(c_reg);
                res_reg.fix_kind       <= FIX_COASTED;
                res_reg.position_valid <= locked_reg ? 1'b0 : ev.in_valid;
            end
            default: ;
        endcase
    end

    // Output register: loaded from the finished result when it is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_FIN && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_word_reg <= res_reg;
        end
    end

    assign s_ready = s_ready_c;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // The search never checks an entry beyond the segments in use.
    a_chk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_vld_reg |-> chk_idx_reg <= n_last)
        else $error("search checked an entry beyond the table in use");

    // Once locked, the tracker only unlocks through reset.
    a_lock_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(locked_reg))
        else $error("tracker lost lock without reset");

    // A failed search leaves the tracker unlocked.
    a_fail_unlocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && res_reg.fix_kind == FIX_FAILED) |-> !locked_reg)
        else $error("failed search while locked");

    // A finished result always names a segment in use.
    a_seg_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> (res_reg.track_index <= TRK_W'(n_last)))
        else $error("result segment beyond the table in use");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bpt_pkg::*;

    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_SAMPLES = 113;

    typedef enum int {
        LAYOUT_RAMP,
        LAYOUT_CHAIN,
        LAYOUT_OVERLAP,
        LAYOUT_TOP,
        LAYOUT_NOISE
    } layout_e;

    // Tracks the segment table, the lock state and the registers, and keeps
    // the position fixes that the block still owes.
    class track_fix_scoreboard;
        bit [31:0] code_start [TABLE_DEPTH];
        bit [31:0] code_end [TABLE_DEPTH];
        bit [31:0] true_start [TABLE_DEPTH];
        bit [31:0] true_end [TABLE_DEPTH];
        bit [5:0]  cur_seg;
        bit [31:0] last_good;
        bit        locked;
        bit [6:0]  entries_reg;
        bit [9:0]  gain_reg;
        bit [19:0] margin_reg;
        out_word_t pending_fixes [$];
        int        mismatch_count;

        function new();
            cur_seg = '0;
            last_good = '0;
            locked = 1'b0;
            entries_reg = TABLE_ENTRIES_RST;
            gain_reg = COAST_GAIN_RST;
            margin_reg = RANGE_MARGIN_RST;
            mismatch_count = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_TABLE_ENTRIES: entries_reg = data[6:0];
                CFG_COAST_GAIN:    gain_reg = data[9:0];
                CFG_RANGE_MARGIN:  margin_reg = data;
                default: ;
            endcase
        endfunction

        // Segments in use, held to the range the table supports.
        function int seg_count();
            int n;
            n = entries_reg;
            if (n < 2) n = 2;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            return n;
        endfunction

        function bit [31:0] clamp_pos(longint v);
            if (v < 0) return '0;
            if (v > 64'd4294967295) return '1;
            return v[31:0];
        endfunction

        // Window test on entry i; the upper margin depends on direction.
        function bit guard_hit(longint b, int i, longint lo_m, longint hi_up, longint hi_dn);
            longint cs, ce;
            cs = code_start[i];
            ce = code_end[i];
            if (cs < ce) return (b >= cs + lo_m) && (b <= ce - hi_up);
            return (b <= cs - hi_dn) && (b >= ce + lo_m);
        endfunction

        function bit in_reach(longint b, int i);
            return guard_hit(b, i, margin_reg, margin_reg, margin_reg);
        endfunction

        function bit hit_valid(longint b, int i);
            return guard_hit(b, i, VALID_LO, VALID_HI_UP, VALID_HI_DN);
        endfunction

        function bit [31:0] map_reading(longint b, int i);
            longint cs, ce, ts;
            cs = code_start[i];
            ce = code_end[i];
            ts = true_start[i];
            if (cs <= ce) return clamp_pos(ts + (b - cs));
            return clamp_pos(ts + (cs - b));
        endfunction

        // One tracking step: nearer neighbor, then current, then coast.
        function bit [1:0] step_fix(longint b, inout int seg, input longint prev,
                                    input longint vel, input int n,
                                    output bit [31:0] pos);
            int c, lo, hi, other;
            longint dl, dh;
            c = seg;
            lo = (c == 0) ? 0 : c - 1;
            hi = (c >= n - 1) ? c : c + 1;
            if (lo == c) begin
                other = hi;
            end else if (hi == c) begin
                other = lo;
            end else begin
                dl = prev - longint'(true_end[lo]);
                dh = prev - longint'(true_start[hi]);
                if (dl < 0) dl = -dl;
                if (dh < 0) dh = -dh;
                other = (dl <= dh) ? lo : hi;
            end
            if (in_reach(b, other)) begin
                seg = other;
                pos = map_reading(b, other);
                return FIX_NEIGHBOR;
            end
            if (in_reach(b, c)) begin
                pos = map_reading(b, c);
                return FIX_CURRENT;
            end
            // Arithmetic shift gives the floor of velocity * gain / 256.
            pos = clamp_pos(prev + ((vel * longint'(gain_reg)) >>> 8));
            return FIX_COASTED;
        endfunction

        // Called for every accepted input word.
        function void note_word(in_word_t w);
            int n, seg;
            longint b, vel;
            bit [31:0] pos;
            bit [1:0] kind;
            bit ok, found;
            out_word_t fix;
            if (w.func == FUNC_LOAD) begin
                code_start[w.entry_index] = w.seg_code_start;
                code_end[w.entry_index] = w.seg_code_end;
                true_start[w.entry_index] = w.seg_true_start;
                true_end[w.entry_index] = w.seg_true_end;
                return;
            end
            n = seg_count();
            b = w.raw_position;
            vel = $signed(w.raw_velocity);
            pos = '0;
            seg = 0;
            ok = 1'b0;
            found = 1'b0;
            if (locked) begin
                seg = (cur_seg >= n) ? n - 1 : cur_seg;
                kind = step_fix(b, seg, last_good, vel, n, pos);
                ok = (kind != FIX_COASTED);
                if (ok) last_good = pos;
                cur_seg = seg;
            end else begin
                // First segment whose guarded range holds the reading.
                for (int i = 0; i < n; i++) begin
                    if (!found && in_reach(b, i)) begin
                        found = 1'b1;
                        seg = i;
                    end
                end
                if (found) begin
                    kind = step_fix(b, seg, b, vel, n, pos);
                    ok = hit_valid(b, seg);
                    locked = 1'b1;
                    cur_seg = seg;
                    last_good = pos;
                end else begin
                    kind = FIX_FAILED;
                    pos = '0;
                    seg = 0;
                end
            end
            fix.abs_position = pos;
            fix.track_index = seg[5:0];
            fix.fix_kind = kind;
            fix.position_valid = ok;
            pending_fixes.push_back(fix);
        endfunction

        function void compare_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                mismatch_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, exp_v, act_v);
            end
        endfunction

        // Called for every accepted result word.
        function void check_fix(out_word_t got);
            out_word_t want;
            if (pending_fixes.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = pending_fixes.pop_front();
            compare_field("abs_position", want.abs_position, got.abs_position);
            compare_field("track_index", want.track_index, got.track_index);
            compare_field("fix_kind", want.fix_kind, got.fix_kind);
            compare_field("position_valid", want.position_valid, got.position_valid);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_word = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_word;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    track_fix_scoreboard sb = new();
    bit steady = 1'b0;
    int stall_left = 0;

    segmented_barcode_position_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_word_t random_word(logic func);
        in_word_t w;
        w.func = func;
        w.entry_index = $urandom_range(0, TABLE_DEPTH - 1);
        w.seg_code_start = $urandom;
        w.seg_code_end = $urandom;
        w.seg_true_start = $urandom;
        w.seg_true_end = $urandom;
        w.raw_position = $urandom;
        w.raw_velocity = $urandom_range(0, 16'hFFFF);
        return w;
    endfunction

    function automatic in_word_t sample_word(logic [31:0] reading, logic signed [15:0] vel);
        in_word_t w;
        w = random_word(FUNC_SAMPLE);
        w.raw_position = reading;
        w.raw_velocity = vel;
        return w;
    endfunction

    function automatic logic [31:0] mid_of(int k);
        return (longint'(sb.code_start[k]) + longint'(sb.code_end[k])) / 2;
    endfunction

    // Random sample, mostly aimed at the current segment or its neighbors.
    function automatic in_word_t make_sample();
        in_word_t w;
        int n, c, j, r;
        longint lo, hi, m, b;
        longint unsigned rnd;
        w = random_word(FUNC_SAMPLE);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: w.raw_velocity = 16'sh8000;
                1: w.raw_velocity = 16'sh7FFF;
                2: w.raw_velocity = 16'sh0000;
                default: w.raw_velocity = 16'shFFFF;
            endcase
        end
        n = sb.seg_count();
        c = (sb.cur_seg >= n) ? n - 1 : sb.cur_seg;
        r = $urandom_range(0, 99);
        if (r >= 85) return w;
        j = (r < 70) ? c - 1 + int'($urandom_range(0, 2)) : int'($urandom_range(0, n - 1));
        if (j < 0) j = 0;
        if (j > n - 1) j = n - 1;
        lo = sb.code_start[j];
        hi = sb.code_end[j];
        if (lo > hi) begin
            b = lo;
            lo = hi;
            hi = b;
        end
        m = sb.margin_reg;
        case ($urandom_range(0, 9))
            0: b = lo + m - 1;
            1: b = lo + m;
            2: b = hi - m;
            3: b = hi - m + 1;
            4: b = lo + VALID_LO;
            5: b = hi - VALID_HI_UP;
            6: b = hi - VALID_HI_DN;
            default: begin
                rnd = {$urandom, $urandom};
                b = lo + longint'(rnd % longint'(hi - lo + 1));
            end
        endcase
        w.raw_position = sb.clamp_pos(b);
        return w;
    endfunction

    // Rewrites one entry with a variant of what it holds (random for the noise
    // layout), so every entry stays loaded.
    function automatic in_word_t reload_word(layout_e style);
        in_word_t w;
        int e;
        w = random_word(FUNC_LOAD);
        if (style == LAYOUT_NOISE) return w;
        e = w.entry_index;
        if ($urandom_range(0, 1)) begin
            w.seg_code_start = sb.code_start[e];
            w.seg_code_end = sb.code_end[e];
        end else begin
            w.seg_code_start = sb.code_end[e];
            w.seg_code_end = sb.code_start[e];
        end
        w.seg_true_start = sb.true_start[e] + $urandom_range(0, 4000);
        w.seg_true_end = sb.true_end[e];
        return w;
    endfunction

    // Presents one input word and returns at the edge that accepts it.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
        cfg_we <= 1'b0;
    endtask

    // Stops sending and lets the block drain and go idle.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_fixes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Loads all entries with a track of the given shape.
    task automatic load_layout(input layout_e style);
        in_word_t w;
        longint p, t, len;
        bit up;
        p = (style == LAYOUT_RAMP) ? 0 : $urandom_range(0, 1000000);
        t = (style == LAYOUT_RAMP) ? 0 : $urandom_range(0, 3000000);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w = random_word(FUNC_LOAD);
            w.entry_index = i;
            len = $urandom_range(100000, 1500000);
            // Equal start and end codes now and then.
            if (style != LAYOUT_RAMP && $urandom_range(0, 15) == 0) len = 0;
            up = (style == LAYOUT_RAMP) || $urandom_range(0, 1);
            if (style != LAYOUT_NOISE) begin
                w.seg_code_start = up ? p : p + len;
                w.seg_code_end = up ? p + len : p;
                if (style == LAYOUT_TOP) begin
                    w.seg_true_start = 32'hFFFFFFFF - $urandom_range(0, 2 * len);
                    w.seg_true_end = 32'hFFFFFFFF;
                end else begin
                    w.seg_true_start = t;
                    w.seg_true_end = t + len;
                end
            end
            p += (style == LAYOUT_OVERLAP) ? len - $urandom_range(0, len / 2) : len;
            t += len;
            send_word(w);
        end
    endtask

    // Result side: checks each accepted word and stalls at random.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_fix(m_word);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        #(64'd20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int entries, gain, margin;
        layout_e style;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Unlocked searches that find nothing, first over two entries.
        load_layout(LAYOUT_RAMP);
        send_word(sample_word(32'd0, 16'sd0));
        send_word(sample_word(32'hFFFFFFFF, 16'sh7FFF));
        send_word(sample_word(mid_of(5), 16'shFFFF));
        settle();
        write_reg(CFG_TABLE_ENTRIES, TABLE_DEPTH);
        send_word(sample_word(32'hFFFFFFFF, 16'sh8000));

        // Lock on the first segment just inside its guard band.
        send_word(sample_word(32'd5000, 16'sd0));

        // Coasting below zero, upward and by the smallest negative step.
        send_word(sample_word(32'hFFFFFFFF, 16'sh8000));
        send_word(sample_word(32'hFFFFFFFF, 16'sh7FFF));
        send_word(sample_word(32'hFFFFFFFF, 16'shFFFF));

        // Neighbor match, current match, equal neighbor distances.
        send_word(sample_word(mid_of(1), 16'sd0));
        send_word(sample_word(mid_of(1), 16'sd0));
        send_word(sample_word(mid_of(2), 16'sd100));
        send_word(sample_word(sb.code_end[1] - 32'd5000, 16'sd0));
        send_word(sample_word(mid_of(2), 16'sd0));
        send_word(sample_word(mid_of(40), 16'sd0));
        send_word(sample_word(sb.code_start[2] + 32'd4999, 16'sd0));

        // Segment count below the minimum with the current segment beyond it.
        settle();
        write_reg(CFG_TABLE_ENTRIES, 1);
        send_word(sample_word(mid_of(1), 16'sd0));

        // Zero margin on a shared boundary, then coasting with zero gain.
        settle();
        write_reg(CFG_TABLE_ENTRIES, 3);
        write_reg(CFG_COAST_GAIN, 0);
        write_reg(CFG_RANGE_MARGIN, 0);
        send_word(sample_word(sb.code_start[2], 16'sd0));
        send_word(sample_word(32'hFFFFFFFF, 16'sh7FFF));

        // Random phases, each with its own registers and track shape.
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin entries = 64;  gain = 128;  margin = 5000;    style = LAYOUT_CHAIN;   end
                1: begin entries = 0;   gain = 1023; margin = 0;       style = LAYOUT_OVERLAP; end
                2: begin entries = 127; gain = 0;    margin = 1048575; style = LAYOUT_CHAIN;   end
                3: begin entries = 1;   gain = 512;  margin = 1000;    style = LAYOUT_TOP;     end
                4: begin entries = 65;  gain = 300;  margin = 20000;   style = LAYOUT_NOISE;   end
                5: begin entries = 37;  gain = 1023; margin = 0;       style = LAYOUT_RAMP;    end
                default: begin
                    entries = $urandom_range(0, 127);
                    gain = $urandom_range(0, 1023);
                    margin = $urandom_range(0, 30000);
                    style = layout_e'($urandom_range(0, 4));
                end
            endcase
            write_reg(CFG_TABLE_ENTRIES, entries);
            write_reg(CFG_COAST_GAIN, gain);
            write_reg(CFG_RANGE_MARGIN, margin);
            load_layout(style);
            steady = (ph == 3);
            repeat (PHASE_SAMPLES) begin
                if ($urandom_range(0, 99) < 8) send_word(reload_word(style));
                else send_word(make_sample());
            end
            steady = 1'b0;
        end

        settle();
        if (sb.mismatch_count == 0 && sb.pending_fixes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
